[hdl/okhi_pkg.sv]
// Package for the offset-keyed hash index: field widths, codes, FSM states
// and the command/status structs between controller and datapath.
// No dependencies.
package okhi_pkg;

    // Beat field widths
    localparam int FUNC_W      = 2;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_NUM_W = 9;
    localparam int PROBE_W     = 11;
    localparam int TOTAL_W     = 32;
    localparam int CFG_W       = 4;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SLOTS = 1024;
    localparam int DEF_KEY_BITS  = 32;

    // slots_log2 after reset and its lower clamp
    localparam logic [CFG_W-1:0] SLOTS_LOG2_RESET = 4'd10;
    localparam int               MIN_SLOTS_LOG2   = 4;

    // FNV-1a, one key byte per round, low byte first
    localparam logic [31:0] FNV_BASIS   = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME   = 32'h0100_0193;
    localparam int          HASH_ROUNDS = 4;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 2'd0,
        FN_INSERT = 2'd1,
        FN_LOOKUP = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLEARED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ENT_ZERO,
        ENT_NEXT,
        ENT_SLOT
    } t_entry_src;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_WIPE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       take_item;
        logic       clear_stats;
        logic       wipe_start;
        logic       wipe_write;
        logic       hash_step;
        logic       rd_en;
        logic       slot_write;
        logic       probe_next;
        logic       count_probe;
        logic       set_result;
        t_status    status_code;
        t_entry_src entry_src;
        logic       bump_entry;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              table_full;
        logic              hash_last;
        logic              slot_empty;
        logic              key_match;
        logic              probe_last;
        logic              wipe_last;
        logic              out_free;
    } t_dp_stat;

endpackage

[hdl/okhi_if.sv]
// Valid/ready channel interfaces for the hash index: request beats in,
// result beats out. Depends on okhi_pkg.
interface okhi_in_if;
    import okhi_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;

    modport source (output valid, func, key, input ready);
    modport sink   (input valid, func, key, output ready);
endinterface

interface okhi_out_if;
    import okhi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [ENTRY_NUM_W-1:0] entry_number;
    logic [PROBE_W-1:0]     probe_count;
    logic [TOTAL_W-1:0]     lookup_total;
    logic [TOTAL_W-1:0]     compare_total;

    modport source (output valid, status, entry_number, probe_count, lookup_total,
                    compare_total, input ready);
    modport sink   (input valid, status, entry_number, probe_count, lookup_total,
                    compare_total, output ready);
endinterface

[hdl/okhi_ctrl.sv]
// Controller FSM for the hash index: sequences wipe, hash rounds and the
// probe loop. Depends on okhi_pkg (state, command and status types).
module okhi_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  okhi_pkg::t_dp_stat i_stat,
    output okhi_pkg::t_dp_cmd  o_cmd
);
    import okhi_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.status_code = ST_NOT_FOUND;
        o_cmd.entry_src   = ENT_ZERO;
        o_in_ready       = 1'b0;

        case (r_state)
            S_INIT: begin
                o_cmd.wipe_write = 1'b1;
                if (i_stat.wipe_last) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                case (i_stat.func)
                    FN_CLEAR: begin
                        o_cmd.clear_stats = 1'b1;
                        o_cmd.wipe_start  = 1'b1;
                        o_cmd.set_result  = 1'b1;
                        o_cmd.status_code = ST_CLEARED;
                        n_state           = S_WIPE;
                    end
                    FN_INSERT: begin
                        if (i_stat.table_full) begin
                            o_cmd.set_result  = 1'b1;
                            o_cmd.status_code = ST_FULL;
                            n_state           = S_DONE;
                        end else begin
                            n_state = S_HASH;
                        end
                    end
                    FN_LOOKUP: begin
                        n_state = S_HASH;
                    end
                    default: begin
                        o_cmd.set_result  = 1'b1;
                        o_cmd.status_code = ST_NOT_FOUND;
                        n_state           = S_DONE;
                    end
                endcase
            end

            S_WIPE: begin
                o_cmd.wipe_write = 1'b1;
                if (i_stat.wipe_last) begin
                    n_state = S_DONE;
                end
            end

            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = S_READ;
                end
            end

            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CHECK;
            end

            S_CHECK: begin
                if (i_stat.func == FN_INSERT) begin
                    if (i_stat.slot_empty) begin
                        o_cmd.slot_write  = 1'b1;
                        o_cmd.set_result  = 1'b1;
                        o_cmd.status_code = ST_INSERTED;
                        o_cmd.entry_src   = ENT_NEXT;
                        o_cmd.bump_entry  = 1'b1;
                        n_state           = S_DONE;
                    end else if (i_stat.key_match) begin
                        // first entry kept, number still consumed
                        o_cmd.set_result  = 1'b1;
                        o_cmd.status_code = ST_DUPLICATE;
                        o_cmd.entry_src   = ENT_SLOT;
                        o_cmd.bump_entry  = 1'b1;
                        n_state           = S_DONE;
                    end else if (i_stat.probe_last) begin
                        o_cmd.set_result  = 1'b1;
                        o_cmd.status_code = ST_FULL;
                        n_state           = S_DONE;
                    end else begin
                        o_cmd.probe_next = 1'b1;
                        n_state          = S_READ;
                    end
                end else begin
                    if (i_stat.slot_empty) begin
                        o_cmd.set_result  = 1'b1;
                        o_cmd.status_code = ST_NOT_FOUND;
                        n_state           = S_DONE;
                    end else begin
                        o_cmd.count_probe = 1'b1;
                        if (i_stat.key_match) begin
                            o_cmd.set_result  = 1'b1;
                            o_cmd.status_code = ST_FOUND;
                            o_cmd.entry_src   = ENT_SLOT;
                            n_state           = S_DONE;
                        end else if (i_stat.probe_last) begin
                            o_cmd.set_result  = 1'b1;
                            o_cmd.status_code = ST_NOT_FOUND;
                            n_state           = S_DONE;
                        end else begin
                            o_cmd.probe_next = 1'b1;
                            n_state          = S_READ;
                        end
                    end
                end
            end

            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

[hdl/okhi_dp.sv]
// Datapath for the hash index: slot memory, FNV-1a round unit, probe
// pointer, entry and total counters, output register. Depends on okhi_pkg
// and okhi_out_if.
module okhi_dp #(
    parameter int MAX_SLOTS = okhi_pkg::DEF_MAX_SLOTS,
    parameter int KEY_BITS  = okhi_pkg::DEF_KEY_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [okhi_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic [okhi_pkg::FUNC_W-1:0]  i_func,
    input  logic [okhi_pkg::KEY_W-1:0]   i_key,
    input  okhi_pkg::t_dp_cmd            i_cmd,
    output okhi_pkg::t_dp_stat           o_stat,
    okhi_out_if.source                   o_result
);
    import okhi_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SLOTS);
    localparam int WORD_W = KEY_BITS + ADDR_W;

    // slot word: {key, ref}; ref is entry number plus one, zero when empty
    logic [WORD_W-1:0] r_mem [MAX_SLOTS];
    logic [WORD_W-1:0] r_rd_word;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic [CFG_W-1:0]    r_slots_log2;
    logic [FUNC_W-1:0]   r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_hash;
    logic [31:0]         n_hash;
    logic [1:0]          r_round;
    logic [ADDR_W-1:0]   r_p;
    logic [ADDR_W-1:0]   r_n;
    logic [ADDR_W:0]     r_probes;
    logic [ADDR_W-1:0]   r_next_entry;
    logic [ADDR_W-1:0]   r_wipe_addr;
    logic [TOTAL_W-1:0]  r_lookups;
    logic [TOTAL_W-1:0]  r_compares;
    logic [TOTAL_W-1:0]  n_lookups;
    logic [TOTAL_W-1:0]  n_compares;
    logic [TOTAL_W:0]    cmp_sum;
    t_status             r_res_status;
    logic [ADDR_W-1:0]   r_res_entry;
    logic                r_out_valid;

    logic [4:0]          cfg_lg;
    logic [4:0]          lg;
    logic [ADDR_W-1:0]   mask;
    logic [31:0]         key32;
    logic [7:0]          key_byte;
    logic [ADDR_W-1:0]   rd_ref;
    logic [KEY_BITS-1:0] rd_key;

    // effective slot count: clamp to [MIN_SLOTS_LOG2, ADDR_W]
    always_comb begin
        cfg_lg = 5'(r_slots_log2);
        if (cfg_lg < 5'(MIN_SLOTS_LOG2)) begin
            lg = 5'(MIN_SLOTS_LOG2);
        end else if (cfg_lg > 5'(ADDR_W)) begin
            lg = 5'(ADDR_W);
        end else begin
            lg = cfg_lg;
        end
        for (int i = 0; i < ADDR_W; i++) begin
            mask[i] = (5'(i) < lg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_log2 <= SLOTS_LOG2_RESET;
        end else if (i_cfg_wr_en) begin
            r_slots_log2 <= i_cfg_wr_data;
        end
    end

    // one FNV-1a round per cycle
    assign key32    = 32'(r_key);
    assign key_byte = 8'(key32 >> {r_round, 3'b000});
    assign n_hash   = (r_hash ^ 32'(key_byte)) * FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_func  <= i_func;
            r_key   <= i_key[KEY_BITS-1:0];
            r_hash  <= FNV_BASIS;
            r_round <= '0;
        end else if (i_cmd.hash_step) begin
            r_hash  <= n_hash;
            r_round <= r_round + 2'd1;
        end
    end

    // probe pointer, pass counter, compare count
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_probes <= '0;
        end else if (i_cmd.count_probe) begin
            r_probes <= r_probes + 1'b1;
        end
        if (i_cmd.hash_step && o_stat.hash_last) begin
            r_p <= n_hash[ADDR_W-1:0] & mask;
            r_n <= '0;
        end else if (i_cmd.probe_next) begin
            r_p <= (r_p + 1'b1) & mask;
            r_n <= r_n + 1'b1;
        end
    end

    // slot memory
    always_comb begin
        mem_we    = i_cmd.wipe_write || i_cmd.slot_write;
        mem_waddr = i_cmd.wipe_write ? r_wipe_addr : r_p;
        mem_wdata = i_cmd.wipe_write ? '0 : {r_key, r_next_entry + 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= r_mem[r_p];
        end
    end

    assign rd_ref = r_rd_word[ADDR_W-1:0];
    assign rd_key = r_rd_word[WORD_W-1:ADDR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wipe_addr <= '0;
        end else if (i_cmd.wipe_start) begin
            r_wipe_addr <= '0;
        end else if (i_cmd.wipe_write) begin
            r_wipe_addr <= r_wipe_addr + 1'b1;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_result) begin
            r_res_status <= i_cmd.status_code;
            case (i_cmd.entry_src)
                ENT_NEXT: r_res_entry <= r_next_entry;
                ENT_SLOT: r_res_entry <= rd_ref - 1'b1;
                default:  r_res_entry <= '0;
            endcase
        end
    end

    // saturating totals, updated as a lookup result leaves
    always_comb begin
        cmp_sum    = {1'b0, r_compares} + (TOTAL_W + 1)'(r_probes);
        n_lookups  = r_lookups;
        n_compares = r_compares;
        if (r_func == FN_LOOKUP) begin
            if (r_lookups != '1) begin
                n_lookups = r_lookups + 1'b1;
            end
            n_compares = cmp_sum[TOTAL_W] ? '1 : cmp_sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_entry <= '0;
            r_lookups    <= '0;
            r_compares   <= '0;
        end else if (i_cmd.clear_stats) begin
            r_next_entry <= '0;
            r_lookups    <= '0;
            r_compares   <= '0;
        end else begin
            if (i_cmd.bump_entry) begin
                r_next_entry <= r_next_entry + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_lookups  <= n_lookups;
                r_compares <= n_compares;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result.status        <= r_res_status;
            o_result.entry_number  <= ENTRY_NUM_W'(r_res_entry);
            o_result.probe_count   <= PROBE_W'(r_probes);
            o_result.lookup_total  <= n_lookups;
            o_result.compare_total <= n_compares;
        end
    end

    assign o_result.valid = r_out_valid;

    always_comb begin
        o_stat.func       = r_func;
        o_stat.table_full = r_next_entry > {1'b0, mask[ADDR_W-1:1]};
        o_stat.hash_last  = r_round == 2'(HASH_ROUNDS - 1);
        o_stat.slot_empty = rd_ref == '0;
        o_stat.key_match  = rd_key == r_key;
        o_stat.probe_last = r_n == mask;
        o_stat.wipe_last  = r_wipe_addr == '1;
        o_stat.out_free   = !r_out_valid || o_result.ready;
    end

endmodule

[hdl/offset_keyed_hash_index.sv]
// Top level of the offset-keyed hash index: open addressing, linear probing,
// FNV-1a slot hash. Depends on okhi_pkg, okhi_if, okhi_ctrl, okhi_dp.
//
//   channel   dir  beat contents
//   -------   ---  -------------------------------------------------------
//   i_item    in   func (clear/insert/lookup), key
//   o_result  out  status, entry_number, probe_count, lookup_total,
//                  compare_total
//   i_cfg_*   in   slots_log2, written whenever i_cfg_wr_en is high
//
// One request at a time. Insert/lookup: a dispatch state, HASH_ROUNDS hash
// rounds (one FNV round per cycle on the single 32x32 multiplier), then a
// read state and a compare state per slot (registered memory read, then
// compare; the empty slot that ends a probe counts as a read), then the
// result state. An insert into a full table goes from dispatch straight to
// the result state. Clear wipes every slot, one per cycle, then reaches the
// result state.
// After reset the same wipe runs with i_item.ready low;
// config writes are taken throughout.
// The output register holds a finished beat while the next request is
// accepted and worked on; only the result cycle waits on o_result.ready.
module offset_keyed_hash_index #(
    parameter int MAX_SLOTS = okhi_pkg::DEF_MAX_SLOTS,
    parameter int KEY_BITS  = okhi_pkg::DEF_KEY_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [okhi_pkg::CFG_W-1:0] i_cfg_wr_data,
    okhi_in_if.sink                    i_item,
    okhi_out_if.source                 o_result
);
    import okhi_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    okhi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    okhi_dp #(
        .MAX_SLOTS (MAX_SLOTS),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_func        (i_item.func),
        .i_key         (i_item.key),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_result      (o_result)
    );

endmodule
